// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Check a property at every clock edge, reset cycles included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: src/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Types and constants shared by the multiplexed stream deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned LenW      = 32;
    localparam int unsigned PosW      = 3;

    // Largest legal frame type byte
    localparam logic [ByteW-1:0] TypeMax     = 8'h03;
    // First header byte that carries the length, and the last header byte
    localparam logic [PosW-1:0]  LengthFirst = 3'd4;
    localparam logic [PosW-1:0]  HeaderLast  = 3'd7;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    // One payload byte offered from the parser to the output stage
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] data;
    } t_beat;

endpackage

`default_nettype wire

// File: src/msd_parser.sv
// ----------------------------------------------------------------------------
// msd_parser
// Input register and frame parser: strips headers, passes payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_parser (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire  [msd_pkg::ByteW-1:0]  i_in_byte,
    input  wire                        i_in_start,
    input  wire                        i_out_ready,
    output msd_pkg::t_beat             o_beat
);
    import msd_pkg::*;

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_start;

    t_phase           r_phase,  n_phase;
    logic [PosW-1:0]  r_pos,    n_pos;
    logic [LenW-1:0]  r_acc,    n_acc;
    logic [LenW-1:0]  r_rem,    n_rem;

    logic             consume;
    logic             emit;
    t_phase           cur_phase;
    logic [PosW-1:0]  cur_pos;
    logic [LenW-1:0]  cur_acc;
    logic [LenW-1:0]  cur_rem;
    logic [LenW-1:0]  rem_dec;

    // Process the held byte once the output stage has room
    assign consume    = r_in_valid && i_out_ready;
    assign o_in_ready = !r_in_valid || consume;

    // Hold the next input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_in_byte;
            r_in_start <= i_in_start;
        end
    end

    // Start flag restarts the parser before the byte is handled
    always_comb begin
        cur_phase = r_in_start ? PH_HUNT : r_phase;
        cur_pos   = r_in_start ? '0 : r_pos;
        cur_acc   = r_in_start ? '0 : r_acc;
        cur_rem   = r_in_start ? '0 : r_rem;
    end

    assign rem_dec = cur_rem - LenW'(1);

    // Advance the parser by one byte
    always_comb begin
        n_phase = cur_phase;
        n_pos   = cur_pos;
        n_acc   = cur_acc;
        n_rem   = cur_rem;
        emit    = 1'b0;
        unique case (cur_phase)
            PH_HEADER: begin
                if (cur_pos >= LengthFirst) begin
                    n_acc = {cur_acc[LenW-ByteW-1:0], r_in_byte};
                end
                if (cur_pos == HeaderLast) begin
                    n_rem   = n_acc;
                    n_pos   = '0;
                    n_phase = (n_acc == '0) ? PH_HUNT : PH_PAYLOAD;
                end else begin
                    n_pos = cur_pos + PosW'(1);
                end
            end
            PH_PAYLOAD: begin
                emit  = 1'b1;
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (r_in_byte <= TypeMax) begin
                    n_phase = PH_HEADER;
                    n_pos   = PosW'(1);
                    n_acc   = '0;
                    n_rem   = '0;
                end
            end
        endcase
    end

    // Commit parser state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_pos   <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
        end else if (consume) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

    assign o_beat.valid = consume && emit;
    assign o_beat.data  = r_in_byte;

endmodule

`default_nettype wire

// File: src/msd_out_skid.sv
// ----------------------------------------------------------------------------
// msd_out_skid
// Output register with a skid entry, so ready upstream comes from a flop.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_out_skid (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  msd_pkg::t_beat             i_beat,
    output logic                       o_ready,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [msd_pkg::ByteW-1:0]  o_data
);
    import msd_pkg::*;

    logic             r_out_valid;
    logic [ByteW-1:0] r_out_data;
    logic             r_skid_valid;
    logic [ByteW-1:0] r_skid_data;
    logic             load;

    assign o_ready = !r_skid_valid;
    assign load    = !r_out_valid || i_ready;

    // Refill the output register from skid first, else park a transfer in skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load) begin
            r_out_valid  <= r_skid_valid || i_beat.valid;
            r_skid_valid <= 1'b0;
        end else if (i_beat.valid) begin
            r_skid_valid <= 1'b1;
        end
        if (load) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_beat.data;
        end else if (i_beat.valid && !r_skid_valid) begin
            r_skid_data <= i_beat.data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

// File: src/multiplexed_stream_deframer.sv
// ----------------------------------------------------------------------------
// multiplexed_stream_deframer
// Strips 8-byte length-prefixed headers from a byte stream, passes payload.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the master side takes transfers.
// Each byte passes through an input register, combinational parsing and an
// output register. A payload byte moves from the input register into the
// output register, or into the skid entry while that register is held, and
// the master side sees the output register. The output skid entry keeps
// input ready driven from flops. While the master side stalls, header bytes
// and skipped bytes keep flowing. The next payload byte is parked in the
// skid entry, and the input register then takes one more transfer. After
// that, input stops until the master side drains.
// Headers are a type byte (0..3), three ignored bytes and a 32-bit
// big-endian length; tuser marks the first byte of a new body and restarts
// the header hunt. Header bytes and bytes skipped while hunting yield no
// output transfer.
`default_nettype none

module multiplexed_stream_deframer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] stream_byte
    input  wire  [0:0]  i_s_axis_tuser,   // [0] body_start
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [7:0] payload_byte
);
    import msd_pkg::*;

    t_beat beat;
    logic  skid_ready;

    msd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_byte   (i_s_axis_tdata),
        .i_in_start  (i_s_axis_tuser[0]),
        .i_out_ready (skid_ready),
        .o_beat      (beat)
    );

    msd_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .o_ready (skid_ready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: src/msd_checker.sv
// ----------------------------------------------------------------------------
// msd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_s_axis_tready,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [7:0]  o_m_axis_tdata
);

    // Stalled output transfer holds
    `ASSERT_CLKD(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "output valid dropped while stalled")
    `ASSERT_CLKD(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata), "output data changed while stalled")
    // Input only backs up behind a pending output transfer
    `ASSERT_CLKD(a_ready_backpressure, i_clk, i_rst_n, !o_s_axis_tready |-> o_m_axis_tvalid, "input stalled with no output pending")
    // Reset empties the pipeline
    `ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")
    `ASSERT_ALWAYS(a_reset_in, i_clk, !i_rst_n |=> o_s_axis_tready, "input not ready after reset")

endmodule

bind multiplexed_stream_deframer msd_checker u_msd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
